// File: sv/cpma_pkg.sv
// Shared types and constants for the channel power meter averager.
package cpma_pkg;
  localparam int ChannelsDefault = 8;
  localparam logic [7:0] WindowReset = 8'd25;

  typedef struct packed {
    logic load;      // latch sample, read channel state
    logic div_start; // start serial dividers
    logic write;     // write back channel state, load output
  } cpma_cmd_t;

  typedef struct packed {
    logic div_done;
    logic ch_valid;
  } cpma_sts_t;
endpackage

// File: sv/cpma_div.sv
// Restoring serial divider, one quotient bit per cycle.
module cpma_div #(
  parameter int NW = 64,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;

  assign trial = {rem_r, q_r[NW-1]};

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DW'(trial - {1'b0, den_r});
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign quo = q_r;
  assign done = busy_r && (cnt_r == CW'(1));
endmodule

// File: sv/cpma_datapath.sv
// Per-channel state registers, sums, energy step and division units.
module cpma_datapath #(
  parameter int CHANNELS = cpma_pkg::ChannelsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpma_pkg::cpma_cmd_t  cmd,
  output cpma_pkg::cpma_sts_t  sts,
  input  logic [7:0]           window_samples,
  input  logic [82:0]          in_word,
  output logic [135:0]         out_word,
  output logic                 out_pub
);
  import cpma_pkg::*;
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [23:0] vs_r [CHANNELS];
  logic [22:0] is_r [CHANNELS];
  logic [24:0] ps_r [CHANNELS];
  logic [7:0]  n_r  [CHANNELS];
  logic [63:0] en_r [CHANNELS];
  logic [31:0] lt_r [CHANNELS];
  logic [2:0]  ph_r [CHANNELS];

  logic [2:0]  ch_r;
  logic [CHW-1:0] idx;
  logic [CHW-1:0] in_idx;
  logic [16:0] p_r;
  logic [31:0] now_r;
  logic [23:0] vsum_r;
  logic [22:0] isum_r;
  logic [24:0] psum_r;
  logic [7:0]  n_cur_r;
  logic [46:0] va_r;
  logic [63:0] en_new_r;
  logic        pf_ok_r;
  logic [7:0]  ch_ext;

  assign ch_ext = {5'd0, in_word[2:0]};
  assign idx = CHW'(ch_r);
  assign in_idx = CHW'(in_word[2:0]);
  assign sts.ch_valid = ch_ext < 8'(CHANNELS);

  // serial dividers
  logic [63:0] qv, qi, qp, qf;
  logic dv, di, dp, df;
  logic [63:0] pf_num;
  assign pf_num = 64'(psum_r) * 64'(n_cur_r) * 64'd327680000;

  cpma_div #(.NW(64), .DW(8)) u_dv (.clk, .rst_n, .start(cmd.div_start),
    .num(64'(vsum_r)), .den(n_cur_r), .quo(qv), .done(dv));
  cpma_div #(.NW(64), .DW(8)) u_di (.clk, .rst_n, .start(cmd.div_start),
    .num(64'(isum_r)), .den(n_cur_r), .quo(qi), .done(di));
  cpma_div #(.NW(64), .DW(8)) u_dp (.clk, .rst_n, .start(cmd.div_start),
    .num(64'(psum_r)), .den(n_cur_r), .quo(qp), .done(dp));
  cpma_div #(.NW(64), .DW(47)) u_df (.clk, .rst_n, .start(cmd.div_start),
    .num(pf_num), .den(va_r), .quo(qf), .done(df));
  assign sts.div_done = dv & di & dp & df;

  logic [15:0] pf;
  always_comb begin
    if (!pf_ok_r) pf = '0;
    else if (qf > 64'd32768) pf = 16'd32768;
    else pf = qf[15:0];
  end

  logic [31:0] d;
  assign d = now_r - lt_r[idx];

  // stage work: load picks up sample and forms sums; next cycle forms products
  logic stage2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage2_r <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        vs_r[k] <= '0; is_r[k] <= '0; ps_r[k] <= '0; n_r[k] <= '0;
        en_r[k] <= '0; lt_r[k] <= '0; ph_r[k] <= '0;
      end
    end else begin
      stage2_r <= cmd.load;
      if (cmd.write) begin
        if (n_cur_r >= window_samples) begin
          vs_r[idx] <= '0; is_r[idx] <= '0; ps_r[idx] <= '0; n_r[idx] <= '0;
        end else begin
          vs_r[idx] <= vsum_r; is_r[idx] <= isum_r; ps_r[idx] <= psum_r;
          n_r[idx] <= n_cur_r;
        end
        en_r[idx] <= en_new_r;
        lt_r[idx] <= now_r;
        ph_r[idx] <= (ph_r[idx] >= 3'd4) ? 3'd0 : ph_r[idx] + 3'd1;
      end
    end
    if (cmd.load) begin
      ch_r   <= in_word[2:0];
      p_r    <= in_word[50:34];
      now_r  <= in_word[82:51];
      vsum_r <= vs_r[in_idx] + 24'(in_word[18:3]);
      isum_r <= is_r[in_idx] + 23'(in_word[33:19]);
      psum_r <= ps_r[in_idx] + 25'(in_word[50:34]);
      n_cur_r <= n_r[in_idx] + 8'd1;
    end
    if (stage2_r) begin
      va_r <= 47'(vsum_r) * 47'(isum_r);
      pf_ok_r <= 47'(vsum_r) * 47'(isum_r) > 47'd1000 * 47'(n_cur_r) * 47'(n_cur_r);
      en_new_r <= (lt_r[idx] == 32'd0) ? en_r[idx] : en_r[idx] + 64'(p_r) * 64'(d);
    end
    if (cmd.write) begin
      out_word <= {5'd0, en_new_r, pf, qp[16:0], qi[14:0], qv[15:0], ch_r};
      out_pub  <= ph_r[idx] >= 3'd4;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done) else $error("divide done too early");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> ph_r[idx] <= 3'd4) else $error("phase out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !cmd.load) else $error("start with load");
endmodule

// File: sv/cpma_ctrl.sv
// Sequencer for one sample: read, multiply, divide, write back, present.
module cpma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output cpma_pkg::cpma_cmd_t cmd,
  input  cpma_pkg::cpma_sts_t sts
);
  import cpma_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_START = 3'd2,
                         S_DIV = 3'd3, S_WR = 3'd4;
  logic [2:0] state_r, state_nxt;
  logic ov_r, ov_nxt;
  logic acc;

  // take a new word only while idle; write back once the output slot frees
  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready && sts.ch_valid;
  assign out_tvalid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE:  if (acc) begin cmd.load = 1'b1; state_nxt = S_MUL; end
      S_MUL:   state_nxt = S_START;
      S_START: begin cmd.div_start = 1'b1; state_nxt = S_DIV; end
      S_DIV:   if (sts.div_done) state_nxt = S_WR;
      S_WR:    if (!ov_nxt) begin
        cmd.write = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> out_tvalid) else $error("result lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_tready) else $error("second word taken while busy");
endmodule

// File: sv/channel_power_meter_averager_core.sv
// Top level of the per-channel windowed average and energy meter.
// Usage:
//  - in_*: one sample word per channel reading. Channels at or above
//    CHANNELS are accepted and dropped with no result.
//  - out_*: one result word per kept sample: window averages including this
//    sample, Q15 power factor, running energy in 1e-4 J, publish flag.
//  - cfg_*: window length in samples; write only while idle.
// Sequence: the accepting edge loads the sample, S_MUL forms the products,
// S_START starts the 64-step serial divider that forms the power factor
// and the three averages, which divide in parallel units over the same
// steps; S_WR then writes back. One word is in work at a time; the next
// is taken after the result is loaded into the output register.
// Reset clears all channel sums, counts, energy, timestamps and phases and
// loads a window of 25 samples. When the receiver stalls, the result holds
// in the output register and a finished word waits to write back until the
// register frees.
module channel_power_meter_averager_core #(
  parameter int CHANNELS = cpma_pkg::ChannelsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // channel[2:0], voltage_sample[18:3], current_sample[33:19],
  // power_sample[50:34], now_ms[82:51]
  input  logic [87:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // channel_out[2:0], mean_voltage[18:3], mean_current[33:19],
  // mean_power[50:34], pf_q15[66:51], energy_total[130:67]
  output logic [135:0] out_tdata,
  // publish
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);
  import cpma_pkg::*;

  cpma_cmd_t  cmd;
  cpma_sts_t  sts;
  logic [7:0] window_r;

  // window register; zero acts as one since n >= 0 always holds
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) window_r <= WindowReset;
    else if (cfg_valid) window_r <= cfg_data;
  end

  cpma_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .cmd, .sts
  );

  cpma_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .window_samples(window_r),
    .in_word(in_tdata[82:0]), .out_word(out_tdata), .out_pub(out_tuser)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid || !$rose(out_tvalid))
    else $error("result too early");
endmodule
